/* hdl/nlm_pkg.sv */
// ----------------------------------------------------------------------------
// nlm_pkg
// Shared types and codes for the neighbor liveness monitor: input and result
// beats, the table entry, the register set and the table control bundle.
// ----------------------------------------------------------------------------
package nlm_pkg;

  // Item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;

  // Register indexes (byte address 4*i)
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_NBR_COUNT    = 2'd0;
  localparam logic [1:0] REG_TICK_INTERVAL = 2'd1;
  localparam logic [1:0] REG_FAIL_THRESH  = 2'd2;
  localparam logic [1:0] REG_CONV_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] entry_index;
    logic [7:0] neighbor_id;
    logic       route_changed;
  } in_t;

  typedef struct packed {
    logic        dead_valid;
    logic [7:0]  dead_neighbor;
    logic        converged;
    logic [31:0] elapsed_time;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] cnt;
    logic        alive;
  } entry_t;

  typedef struct packed {
    logic [4:0]  neighbor_count;
    logic [7:0]  tick_interval;
    logic [15:0] failure_threshold;
    logic [15:0] quiet_limit;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* hdl/nlm_regs.sv */
// ----------------------------------------------------------------------------
// nlm_regs
// APB register file holding the monitor configuration.
// ----------------------------------------------------------------------------
module nlm_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [nlm_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output nlm_pkg::cfg_t                cfg_o
);
  import nlm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr_i[3:2];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neighbor_count    <= 5'd0;
      cfg_q.tick_interval     <= 8'd1;
      cfg_q.failure_threshold <= 16'd3;
      cfg_q.quiet_limit       <= 16'd30;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NBR_COUNT:     cfg_q.neighbor_count    <= pwdata_i[4:0];
        REG_TICK_INTERVAL: cfg_q.tick_interval     <= pwdata_i[7:0];
        REG_FAIL_THRESH:   cfg_q.failure_threshold <= pwdata_i[15:0];
        REG_CONV_TIMEOUT:  cfg_q.quiet_limit       <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NBR_COUNT:     prdata_o = 32'(cfg_q.neighbor_count);
      REG_TICK_INTERVAL: prdata_o = 32'(cfg_q.tick_interval);
      REG_FAIL_THRESH:   prdata_o = 32'(cfg_q.failure_threshold);
      REG_CONV_TIMEOUT:  prdata_o = 32'(cfg_q.quiet_limit);
      default:           prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/nlm_table.sv */
// ----------------------------------------------------------------------------
// nlm_table
// Neighbor table memory: one write port, one registered read port. Per-entry
// valid bits make an unwritten entry read as counter zero and alive.
// ----------------------------------------------------------------------------
module nlm_table #(
  parameter int unsigned MAX_NEIGHBORS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nlm_pkg::mem_ctl_t   ctl_i,
  input  logic [((MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1)-1:0] raddr_i,
  input  logic [((MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1)-1:0] waddr_i,
  input  nlm_pkg::entry_t     wdata_i,
  output nlm_pkg::entry_t     rdata_o
);
  import nlm_pkg::*;

  entry_t                   mem [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] valid_q;
  entry_t                   rdata_q;
  logic                     rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // An entry never written reads as its reset value; the id is don't-care.
  always_comb begin
    rdata_o = rdata_q;
    if (!rvalid_q) begin
      rdata_o.cnt   = 16'd0;
      rdata_o.alive = 1'b1;
    end
  end

endmodule

/* hdl/nlm_seq.sv */
// ----------------------------------------------------------------------------
// nlm_seq
// Item sequencer: takes load, tick and update beats, walks the neighbor table
// with a read-modify-write pipeline and emits result beats.
// ----------------------------------------------------------------------------
module nlm_seq #(
  parameter int unsigned MAX_NEIGHBORS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nlm_pkg::cfg_t       cfg_i,
  input  logic                start_i,
  input  nlm_pkg::in_t        item_i,
  output logic                busy_o,
  output nlm_pkg::mem_ctl_t   mem_ctl_o,
  output logic [((MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1)-1:0] raddr_o,
  output logic [((MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1)-1:0] waddr_o,
  output nlm_pkg::entry_t     wdata_o,
  input  nlm_pkg::entry_t     rdata_i,
  output logic                strobe_o,
  output nlm_pkg::out_t       result_o
);
  import nlm_pkg::*;

  localparam int unsigned IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic             op_tick_q;
  logic [7:0]       sid_q;
  logic [IDX_W-1:0] idx_q;
  logic             rd_v_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             pend_q;
  logic [7:0]       pend_id_q;
  logic [31:0]      elapsed_q;
  logic [15:0]      quiet_q;
  logic             change_q;
  logic             conv_q;
  logic             strobe_q;
  out_t             res_q;

  logic [CNT_W-1:0] n_used;
  logic [CNT_W-1:0] n_last;
  logic [32:0]      el_sum;
  logic [31:0]      el_new;
  logic [16:0]      q_sum;
  logic [15:0]      q_new;
  logic [16:0]      c_sum;
  logic [15:0]      c_tick;
  logic [15:0]      c_upd;
  logic             over;
  logic             dies;
  entry_t           wb_entry;
  logic             load_go;

  // Clamp the entry count to the table depth.
  always_comb begin
    if (32'(cfg_i.neighbor_count) > MAX_NEIGHBORS) begin
      n_used = CNT_W'(MAX_NEIGHBORS);
    end else begin
      n_used = CNT_W'(cfg_i.neighbor_count);
    end
    n_last = n_used - CNT_W'(1);
  end

  // Tick arithmetic on the global timers, all saturating.
  always_comb begin
    el_sum = {1'b0, elapsed_q} + 33'(cfg_i.tick_interval);
    el_new = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
    q_sum  = {1'b0, quiet_q} + 17'(cfg_i.tick_interval);
    if (change_q) begin
      q_new = 16'd0;
    end else begin
      q_new = q_sum[16] ? 16'hFFFF : q_sum[15:0];
    end
  end

  // Modify stage for the entry returned by the table.
  always_comb begin
    c_sum  = {1'b0, rdata_i.cnt} + 17'(cfg_i.tick_interval);
    c_tick = c_sum[16] ? 16'hFFFF : c_sum[15:0];
    c_upd  = (rdata_i.id == sid_q) ? 16'd0 : rdata_i.cnt;
    over   = c_upd >= cfg_i.failure_threshold;
    dies   = rd_v_q && !op_tick_q && over && rdata_i.alive;
    wb_entry.id = rdata_i.id;
    if (op_tick_q) begin
      wb_entry.cnt   = c_tick;
      wb_entry.alive = rdata_i.alive;
    end else begin
      wb_entry.cnt   = c_upd;
      wb_entry.alive = !over;
    end
  end

  assign load_go = start_i && (state_q == ST_IDLE) && (item_i.mode == MODE_LOAD) &&
                   (32'(item_i.entry_index) < MAX_NEIGHBORS);

  // Loads write while idle; the walk writes each entry back in the cycle after its read.
  always_comb begin
    mem_ctl_o.rd_en = (state_q == ST_WALK);
    raddr_o         = idx_q;
    if (load_go) begin
      mem_ctl_o.wr_en = 1'b1;
      waddr_o         = IDX_W'(item_i.entry_index);
      wdata_o.id      = item_i.neighbor_id;
      wdata_o.cnt     = 16'd0;
      wdata_o.alive   = 1'b1;
    end else begin
      mem_ctl_o.wr_en = rd_v_q;
      waddr_o         = rd_idx_q;
      wdata_o         = wb_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_tick_q <= 1'b0;
      sid_q     <= 8'd0;
      idx_q     <= '0;
      rd_v_q    <= 1'b0;
      rd_idx_q  <= '0;
      pend_q    <= 1'b0;
      pend_id_q <= 8'd0;
      elapsed_q <= 32'd0;
      quiet_q   <= 16'd0;
      change_q  <= 1'b0;
      conv_q    <= 1'b0;
      strobe_q  <= 1'b0;
      res_q     <= '0;
    end else begin
      strobe_q <= 1'b0;
      rd_v_q   <= 1'b0;

      // A newly dead neighbor pushes out the one held before it.
      if (dies) begin
        change_q  <= 1'b1;
        pend_q    <= 1'b1;
        pend_id_q <= rdata_i.id;
        if (pend_q) begin
          strobe_q <= 1'b1;
          res_q    <= '{dead_valid: 1'b1, dead_neighbor: pend_id_q, converged: 1'b0,
                        elapsed_time: elapsed_q, last: 1'b0};
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            case (item_i.mode)
              MODE_TICK: begin
                elapsed_q <= el_new;
                quiet_q   <= q_new;
                change_q  <= 1'b0;
                conv_q    <= (q_new == cfg_i.quiet_limit) && (q_new != quiet_q);
                op_tick_q <= 1'b1;
                idx_q     <= '0;
                state_q   <= (n_used == '0) ? ST_FINISH : ST_WALK;
              end
              MODE_UPDATE: begin
                if (item_i.route_changed) begin
                  change_q <= 1'b1;
                end
                op_tick_q <= 1'b0;
                sid_q     <= item_i.neighbor_id;
                idx_q     <= '0;
                state_q   <= (n_used == '0) ? ST_FINISH : ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          rd_v_q   <= 1'b1;
          rd_idx_q <= idx_q;
          idx_q    <= idx_q + IDX_W'(1);
          if (CNT_W'(idx_q) == n_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          strobe_q <= 1'b1;
          if (op_tick_q) begin
            res_q <= '{dead_valid: 1'b0, dead_neighbor: 8'd0, converged: conv_q,
                       elapsed_time: elapsed_q, last: 1'b1};
          end else if (pend_q) begin
            res_q <= '{dead_valid: 1'b1, dead_neighbor: pend_id_q, converged: 1'b0,
                       elapsed_time: elapsed_q, last: 1'b1};
          end else begin
            res_q <= '{dead_valid: 1'b0, dead_neighbor: 8'd0, converged: 1'b0,
                       elapsed_time: elapsed_q, last: 1'b1};
          end
          pend_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && res_q.last |-> state_q == ST_IDLE)
    else $error("final beat shown while a walk is still running");

  a_dead_no_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && res_q.dead_valid |-> !res_q.converged)
    else $error("dead report carries a convergence flag");

  a_rmw_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q && state_q == ST_WALK |-> rd_idx_q != idx_q)
    else $error("read and write back hit the same entry");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.mode == MODE_TICK |=> busy_o)
    else $error("tick accepted without starting a walk");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q && !rd_v_q)
    else $error("idle with a dead report or a read still pending");
`endif

endmodule

/* hdl/neighbor_liveness_monitor.sv */
// ----------------------------------------------------------------------------
// neighbor_liveness_monitor
// Keepalive timeout monitor over a table of routing neighbors, with an APB
// configuration port and a command-style item interface.
// ----------------------------------------------------------------------------
// A load is written to the table while idle. A tick or update walks the
// entries in use (none: straight to finish), drains and finishes; busy stays
// high until then, and a new item is taken only when idle. Its final result
// beat appears in the cycle busy drops. The walk is a single read-modify-write
// pass over the table memory, one entry per cycle. Results cannot be stalled.
// Reset (async, active low) restores register defaults and marks all entries
// unwritten; no clearing pass is needed.
module neighbor_liveness_monitor #(
  parameter int unsigned MAX_NEIGHBORS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  nlm_pkg::in_t                 item_i,
  output logic                         strobe_o,
  output nlm_pkg::out_t                result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nlm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import nlm_pkg::*;

  localparam int unsigned IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  cfg_t             cfg;
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  entry_t           rdata;

  assign pready = 1'b1;

  nlm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  nlm_table #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mem_ctl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  nlm_seq #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .start_i   (start),
    .item_i    (item_i),
    .busy_o    (busy),
    .mem_ctl_o (mem_ctl),
    .raddr_o   (raddr),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .rdata_i   (rdata),
    .strobe_o  (strobe_o),
    .result_o  (result_o)
  );

endmodule

/* tb/sv/neighbor_liveness_monitor_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neighbor_liveness_monitor_tb
// Self-checking bench for the neighbor liveness monitor. A scripted opening
// covers reset behavior, the register extremes, the ignored mode,
// convergence, zero threshold and mass death. Random phases follow, each
// with its own register setting, some with sender idling. Every result beat is
// compared against a cycle-free model of the neighbor table kept here.
// ----------------------------------------------------------------------------
module neighbor_liveness_monitor_tb;
  import nlm_pkg::*;

  localparam int unsigned NBR_DEPTH     = 16;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned QUIET_PHASE   = 2;

  // one line of the scripted opening: a register write or an item beat
  typedef struct packed {
    logic        is_reg;
    logic [1:0]  reg_sel;
    logic [31:0] reg_val;
    in_t         beat;
    logic        typed;
    out_t        typed_res;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  in_t                 beat_q;
  logic                strobe;
  out_t                result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // mirror of the neighbor table and timers
  logic [7:0]  nbr_id     [NBR_DEPTH];
  logic [15:0] nbr_silence[NBR_DEPTH];
  logic        nbr_alive  [NBR_DEPTH];
  logic        nbr_loaded [NBR_DEPTH];
  logic [15:0] quiet_time_m;
  logic [31:0] elapsed_m;
  logic        change_m;
  cfg_t        cfg_m;

  out_t        step_reports[$];
  out_t        reports_due[$];
  script_row_t script[$];

  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned reports_seen;
  int unsigned deaths_seen;
  int unsigned convergences_seen;
  int unsigned settings_run;

  int unsigned ph_count  [NUM_PHASES] = '{8, 31, 16, 1, 0, 12, 16, 5};
  int unsigned ph_tick   [NUM_PHASES] = '{1, 3, 255, 0, 7, 2, 1, 128};
  int unsigned ph_thresh [NUM_PHASES] = '{3, 10, 65535, 1, 2, 5, 0, 256};
  int unsigned ph_timeout[NUM_PHASES] = '{30, 20, 5100, 1, 0, 12, 65535, 1024};
  int unsigned ph_gap    [NUM_PHASES] = '{0, 67, 22, 0, 67, 22, 0, 67};
  int unsigned ph_beats  [NUM_PHASES] = '{25, 25, 45, 25, 25, 30, 30, 30};

  neighbor_liveness_monitor #(
    .MAX_NEIGHBORS(NBR_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (beat_q),
    .strobe_o(strobe),
    .result_o(result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned entries_in_use();
    return (cfg_m.neighbor_count > NBR_DEPTH) ? NBR_DEPTH : int'(cfg_m.neighbor_count);
  endfunction

  function automatic logic [31:0] reg_mask(logic [1:0] sel);
    case (sel)
      REG_NBR_COUNT:     return 32'h0000_001F;
      REG_TICK_INTERVAL: return 32'h0000_00FF;
      default:           return 32'h0000_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] reg_readback(logic [1:0] sel);
    case (sel)
      REG_NBR_COUNT:     return {27'd0, cfg_m.neighbor_count};
      REG_TICK_INTERVAL: return {24'd0, cfg_m.tick_interval};
      REG_FAIL_THRESH:   return {16'd0, cfg_m.failure_threshold};
      default:           return {16'd0, cfg_m.quiet_limit};
    endcase
  endfunction

  function automatic void reset_table_model();
    for (int i = 0; i < NBR_DEPTH; i++) begin
      nbr_id[i]      = 8'd0;
      nbr_silence[i] = 16'd0;
      nbr_alive[i]   = 1'b1;
      nbr_loaded[i]  = 1'b0;
    end
    quiet_time_m = 16'd0;
    elapsed_m    = 32'd0;
    change_m     = 1'b0;
    cfg_m        = '{neighbor_count: 5'd0, tick_interval: 8'd1,
                     failure_threshold: 16'd3, quiet_limit: 16'd30};
  endfunction

  // Apply one accepted beat to the table mirror; results land in step_reports.
  function automatic void advance_liveness(in_t b);
    int unsigned n;
    logic [16:0] sum16;
    logic [32:0] sum32;
    logic [15:0] old_q;
    logic [15:0] new_q;
    out_t        rep;
    n = entries_in_use();
    step_reports.delete();
    case (b.mode)
      MODE_LOAD: begin
        nbr_id[b.entry_index]      = b.neighbor_id;
        nbr_silence[b.entry_index] = 16'd0;
        nbr_alive[b.entry_index]   = 1'b1;
        nbr_loaded[b.entry_index]  = 1'b1;
      end
      MODE_TICK: begin
        old_q = quiet_time_m;
        for (int i = 0; i < n; i++) begin
          sum16 = {1'b0, nbr_silence[i]} + cfg_m.tick_interval;
          nbr_silence[i] = sum16[16] ? 16'hFFFF : sum16[15:0];
        end
        sum32 = {1'b0, elapsed_m} + cfg_m.tick_interval;
        elapsed_m = sum32[32] ? 32'hFFFF_FFFF : sum32[31:0];
        if (change_m) begin
          new_q = 16'd0;
        end else begin
          sum16 = {1'b0, old_q} + cfg_m.tick_interval;
          new_q = sum16[16] ? 16'hFFFF : sum16[15:0];
        end
        quiet_time_m = new_q;
        change_m = 1'b0;
        rep = '{dead_valid: 1'b0, dead_neighbor: 8'd0,
                converged: (new_q == cfg_m.quiet_limit) && (new_q != old_q),
                elapsed_time: elapsed_m, last: 1'b1};
        step_reports.push_back(rep);
      end
      MODE_UPDATE: begin
        for (int i = 0; i < n; i++) begin
          if (nbr_id[i] == b.neighbor_id) nbr_silence[i] = 16'd0;
        end
        if (b.route_changed) change_m = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (nbr_silence[i] >= cfg_m.failure_threshold) begin
            if (nbr_alive[i]) begin
              nbr_alive[i] = 1'b0;
              change_m = 1'b1;
              rep = '{dead_valid: 1'b1, dead_neighbor: nbr_id[i], converged: 1'b0,
                      elapsed_time: elapsed_m, last: 1'b0};
              step_reports.push_back(rep);
            end
          end else begin
            nbr_alive[i] = 1'b1;
          end
        end
        if (step_reports.size() == 0) begin
          rep = '{dead_valid: 1'b0, dead_neighbor: 8'd0, converged: 1'b0,
                  elapsed_time: elapsed_m, last: 1'b1};
          step_reports.push_back(rep);
        end else begin
          step_reports[step_reports.size()-1].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_t random_beat(bit quiet_only);
    in_t         b;
    int unsigned r;
    int unsigned n;
    int          hole;
    r = $urandom_range(0, 99);
    n = entries_in_use();
    b.entry_index   = 4'($urandom);
    b.neighbor_id   = 8'($urandom);
    b.route_changed = ($urandom_range(0, 3) == 0);
    if (quiet_only)   b.mode = (r < 97) ? MODE_TICK : MODE_LOAD;
    else if (r < 5)   b.mode = MODE_UNUSED;
    else if (r < 25)  b.mode = MODE_LOAD;
    else if (r < 60)  b.mode = MODE_TICK;
    else              b.mode = MODE_UPDATE;
    if (b.mode == MODE_UPDATE) begin
      hole = -1;
      for (int i = n - 1; i >= 0; i--) begin
        if (!nbr_loaded[i]) hole = i;
      end
      // fill the table before any update may compare against it
      if (hole >= 0) begin
        b.mode        = MODE_LOAD;
        b.entry_index = 4'(hole);
      end else if (n > 0 && $urandom_range(0, 9) < 7) begin
        b.neighbor_id = nbr_id[$urandom_range(0, n - 1)];
      end
    end
    return b;
  endfunction

  function automatic script_row_t beat_row(logic [1:0] mode, logic [3:0] idx,
                                           logic [7:0] id, logic rc);
    script_row_t row;
    row = '0;
    row.beat = '{mode: mode, entry_index: idx, neighbor_id: id, route_changed: rc};
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [1:0] sel, logic [31:0] val);
    script_row_t row;
    row = '0;
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic script_row_t with_report(script_row_t row, logic [31:0] elapsed);
    row.typed     = 1'b1;
    row.typed_res = '{dead_valid: 1'b0, dead_neighbor: 8'd0, converged: 1'b0,
                      elapsed_time: elapsed, last: 1'b1};
    return row;
  endfunction

  task automatic send_beat(input in_t b, input logic typed, input out_t typed_res);
    start  <= 1'b1;
    beat_q <= b;
    do @(posedge clk_i); while (busy);
    advance_liveness(b);
    if (typed) begin
      reports_due.push_back(typed_res);
    end else begin
      foreach (step_reports[k]) reports_due.push_back(step_reports[k]);
    end
    if (b.mode != MODE_UNUSED) beats_sent++;
    @(negedge clk_i);
  endtask

  // drain outstanding reports, then hold off for any load still in flight
  task automatic settle();
    start <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
    logic [31:0] mask;
    mask = reg_mask(sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({sel, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_NBR_COUNT:     cfg_m.neighbor_count    = val[4:0];
      REG_TICK_INTERVAL: cfg_m.tick_interval     = val[7:0];
      REG_FAIL_THRESH:   cfg_m.failure_threshold = val[15:0];
      default:           cfg_m.quiet_limit       = val[15:0];
    endcase
    @(negedge clk_i);
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= val ^ mask;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== reg_readback(sel)) begin
      $error("prdata: expected %0h, got %0h", reg_readback(sel), prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && strobe) begin
      reports_seen++;
      if (result.dead_valid === 1'b1) deaths_seen++;
      if (result.converged === 1'b1) convergences_seen++;
      if (reports_due.size() == 0) begin
        $error("unexpected result beat: %p", result);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        if (result.dead_valid !== want.dead_valid) begin
          $error("dead_valid: expected %0d, got %0d", want.dead_valid, result.dead_valid);
          mismatches++;
        end
        if (result.dead_neighbor !== want.dead_neighbor) begin
          $error("dead_neighbor: expected %0h, got %0h",
                 want.dead_neighbor, result.dead_neighbor);
          mismatches++;
        end
        if (result.converged !== want.converged) begin
          $error("converged: expected %0d, got %0d", want.converged, result.converged);
          mismatches++;
        end
        if (result.elapsed_time !== want.elapsed_time) begin
          $error("elapsed_time: expected %0d, got %0d",
                 want.elapsed_time, result.elapsed_time);
          mismatches++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    script_row_t row;
    logic [31:0] val;
    int unsigned sent_before;
    int unsigned waited;
    bit          quiet_only;

    mismatches        = 0;
    beats_sent        = 0;
    reports_seen      = 0;
    deaths_seen       = 0;
    convergences_seen = 0;
    settings_run      = 1;
    rst_ni  = 1'b0;
    start   = 1'b0;
    beat_q  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    reset_table_model();

    // reset values, the ignored mode, then a small table through death,
    // revival, convergence, a stuck quiet time and a zero threshold
    script.push_back(with_report(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0), 32'd1));
    script.push_back(with_report(beat_row(MODE_UPDATE, 4'h0, 8'h00, 1'b0), 32'd1));
    script.push_back(beat_row(MODE_UNUSED, 4'hF, 8'hFF, 1'b1));
    script.push_back(beat_row(MODE_LOAD, 4'h0, 8'h00, 1'b0));
    script.push_back(beat_row(MODE_LOAD, 4'h1, 8'hFF, 1'b0));
    script.push_back(beat_row(MODE_LOAD, 4'h2, 8'h5A, 1'b0));
    script.push_back(beat_row(MODE_LOAD, 4'hF, 8'hA5, 1'b1));
    script.push_back(beat_row(MODE_LOAD, 4'h3, 8'h3C, 1'b0));
    script.push_back(reg_row(REG_NBR_COUNT, 32'd4));
    script.push_back(reg_row(REG_FAIL_THRESH, 32'd2));
    script.push_back(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0));
    script.push_back(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0));
    script.push_back(beat_row(MODE_UPDATE, 4'h0, 8'hFF, 1'b0));
    script.push_back(beat_row(MODE_UPDATE, 4'h0, 8'h5A, 1'b0));
    script.push_back(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0));
    script.push_back(reg_row(REG_TICK_INTERVAL, 32'd255));
    script.push_back(reg_row(REG_CONV_TIMEOUT, 32'd255));
    script.push_back(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0));
    script.push_back(reg_row(REG_TICK_INTERVAL, 32'd0));
    script.push_back(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0));
    script.push_back(reg_row(REG_FAIL_THRESH, 32'd0));
    script.push_back(beat_row(MODE_UPDATE, 4'h0, 8'h11, 1'b1));
    script.push_back(beat_row(MODE_TICK, 4'h0, 8'h00, 1'b0));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[r]) begin
      row = script[r];
      if (row.is_reg) begin
        settle();
        write_reg(row.reg_sel, row.reg_val);
        settings_run++;
      end else begin
        send_beat(row.beat, row.typed, row.typed_res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      val = ph_count[p];
      write_reg(REG_NBR_COUNT, val | ($urandom & ~reg_mask(REG_NBR_COUNT)));
      val = ph_tick[p];
      write_reg(REG_TICK_INTERVAL, val | ($urandom & ~reg_mask(REG_TICK_INTERVAL)));
      val = ph_thresh[p];
      write_reg(REG_FAIL_THRESH, val | ($urandom & ~reg_mask(REG_FAIL_THRESH)));
      val = ph_timeout[p];
      write_reg(REG_CONV_TIMEOUT, val | ($urandom & ~reg_mask(REG_CONV_TIMEOUT)));
      settings_run++;
      sent_before = beats_sent;
      while (beats_sent - sent_before < ph_beats[p]) begin
        // keep updates out until quiet time has climbed past the timeout
        quiet_only = (p == QUIET_PHASE) && (beats_sent - sent_before < ph_beats[p] - 10);
        if ($urandom_range(0, 99) < ph_gap[p]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 20)) @(negedge clk_i);
        end
        send_beat(random_beat(quiet_only), 1'b0, '0);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (NBR_DEPTH + 4) @(negedge clk_i);
    if (reports_due.size() != 0) begin
      $error("%0d expected result beats never arrived", reports_due.size());
      mismatches++;
    end

    $display("Covered %0d item beats under %0d register settings.", beats_sent, settings_run);
    $display("Checked %0d result beats: %0d dead reports, %0d convergence reports.",
             reports_seen, deaths_seen, convergences_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* neighbor_liveness_monitor.f */
hdl/nlm_pkg.sv
hdl/nlm_regs.sv
hdl/nlm_table.sv
hdl/nlm_seq.sv
hdl/neighbor_liveness_monitor.sv
tb/sv/neighbor_liveness_monitor_tb.sv
